// ----- rtl/fmp_pkg.sv -----
`default_nettype none

package fmp_pkg;

  localparam int FMP_MAX_WIDTH  = 64;
  localparam int FMP_MAX_HEIGHT = 64;
  localparam int FMP_PIXEL_BITS = 16;

  localparam int CFG_SIZE_BITS  = 7;
  localparam int CFG_SAMP_BITS  = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int POS_BITS       = 6;
  localparam int INDEX_BITS     = 12;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IN_WIDTH    = 3'd0,
    CFG_IN_HEIGHT   = 3'd1,
    CFG_OUT_WIDTH   = 3'd2,
    CFG_OUT_HEIGHT  = 3'd3,
    CFG_POOL_WIDTH  = 3'd4,
    CFG_POOL_HEIGHT = 3'd5,
    CFG_SAMPLE_W    = 3'd6,
    CFG_SAMPLE_H    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_BAD   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_MUL   = 3'd1,
    BK_DIV   = 3'd2,
    BK_SCAN  = 3'd3,
    BK_DRAIN = 3'd4
  } back_state_e;

  typedef struct packed {
    logic [CFG_SIZE_BITS-1:0] in_w;
    logic [CFG_SIZE_BITS-1:0] in_h;
    logic [CFG_SIZE_BITS-1:0] out_w;
    logic [CFG_SIZE_BITS-1:0] out_h;
    logic [CFG_SIZE_BITS-1:0] pool_w;
    logic [CFG_SIZE_BITS-1:0] pool_h;
    logic [CFG_SAMP_BITS-1:0] samp_w;
    logic [CFG_SAMP_BITS-1:0] samp_h;
  } cfg_t;

  typedef struct packed {
    kind_e               kind;
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/fmp_ram.sv -----
`default_nettype none

module fmp_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/fmp_front.sv -----
`default_nettype none

module fmp_front
  import fmp_pkg::*;
#(
  parameter int MAX_WIDTH  = FMP_MAX_WIDTH,
  parameter int MAX_HEIGHT = FMP_MAX_HEIGHT,
  parameter int PIXEL_BITS = FMP_PIXEL_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cfg_t                         cfg_i,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         req_type_i,
  input  wire logic [POS_BITS-1:0]          pixel_row_i,
  input  wire logic [POS_BITS-1:0]          pixel_col_i,
  input  wire logic signed [PIXEL_BITS-1:0] pixel_value_i,
  input  wire logic [POS_BITS-1:0]          out_row_i,
  input  wire logic [POS_BITS-1:0]          out_col_i,
  output item_t                             head_o,
  output logic signed [PIXEL_BITS-1:0]      head_value_o,
  output logic                              empty_o,
  input  wire logic                         pop_i
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t                        item_q  [QUEUE_DEPTH];
  logic signed [PIXEL_BITS-1:0] value_q [QUEUE_DEPTH];
  logic [PW-1:0]                wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]                  cnt_q, cnt_d;

  logic  accept, push, axis_w_ok, axis_h_ok, load_in;
  item_t item_new;

  function automatic logic axis_ok(input logic [CFG_SIZE_BITS-1:0] in_sz,
                                   input logic [CFG_SIZE_BITS-1:0] out_sz,
                                   input logic [CFG_SIZE_BITS-1:0] pool_sz,
                                   input int                       max_sz);
    logic [CFG_SIZE_BITS:0] reach;
    reach = {1'b0, out_sz} + {1'b0, pool_sz} - 1'b1;
    return (in_sz != '0) && (out_sz != '0) && (pool_sz != '0) &&
           (32'(in_sz) <= max_sz) && (reach <= {1'b0, in_sz});
  endfunction

  assign busy_o    = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign accept    = start_i && !busy_o;
  assign axis_w_ok = axis_ok(cfg_i.in_w, cfg_i.out_w, cfg_i.pool_w, MAX_WIDTH);
  assign axis_h_ok = axis_ok(cfg_i.in_h, cfg_i.out_h, cfg_i.pool_h, MAX_HEIGHT);
  assign load_in   = (32'(pixel_row_i) < MAX_HEIGHT) && (32'(pixel_col_i) < MAX_WIDTH);

  // classify: queries are marked good or bad; loads outside the store are dropped here
  always_comb begin
    item_new = '{kind: KIND_LOAD, row: pixel_row_i, col: pixel_col_i};
    push     = accept;
    if (req_type_i) begin
      item_new.row = out_row_i;
      item_new.col = out_col_i;
      if (!axis_w_ok || !axis_h_ok ||
          ({1'b0, out_row_i} >= cfg_i.out_h) || ({1'b0, out_col_i} >= cfg_i.out_w)) begin
        item_new.kind = KIND_BAD;
      end else begin
        item_new.kind = KIND_QUERY;
      end
    end else if (!load_in) begin
      push = 1'b0;
    end
  end

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PW+1)'(push) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      item_q[wr_q]  <= item_new;
      value_q[wr_q] <= pixel_value_i;
    end
  end

  assign head_o       = item_q[rd_q];
  assign head_value_o = value_q[rd_q];
  assign empty_o      = (cnt_q == '0);

endmodule

`default_nettype wire

// ----- rtl/fmp_back.sv -----
`default_nettype none

module fmp_back
  import fmp_pkg::*;
#(
  parameter int MAX_WIDTH  = FMP_MAX_WIDTH,
  parameter int MAX_HEIGHT = FMP_MAX_HEIGHT,
  parameter int PIXEL_BITS = FMP_PIXEL_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cfg_t                         cfg_i,
  input  wire item_t                        head_i,
  input  wire logic signed [PIXEL_BITS-1:0] head_value_i,
  input  wire logic                         empty_i,
  output logic                              pop_o,
  output logic                              res_valid_o,
  output logic signed [PIXEL_BITS-1:0]      max_value_o,
  output logic [INDEX_BITS-1:0]             max_index_o,
  output logic                              bad_query_o
);

  localparam int Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(Depth);
  localparam int SB     = CFG_SIZE_BITS;
  localparam int NUM_W  = 30;
  localparam int DEN_W  = SB + CFG_SAMP_BITS;
  localparam int QB     = SB;

  back_state_e state_q, state_d;

  logic [POS_BITS-1:0]    krow_q, kcol_q;
  logic [1:0]             sel_q, sel_d;
  logic [NUM_W-1:0]       rem_q, rem_d;
  logic [DEN_W-1:0]       den_q, den_d;
  logic [2:0]             bit_q, bit_d;
  logic [QB-1:0]          quot_q, quot_d, qa_q, qa_d;
  logic [SB-1:0]          r0_q, r0_d, c0_q, c0_d, r_q, r_d, c_q, c_d;
  logic                   pv_q, pv_d, first_q, first_d;
  logic [SB-1:0]          pr_q, pc_q;
  logic signed [PIXEL_BITS-1:0] best_q, best_d;
  logic [INDEX_BITS-1:0]  bidx_q, bidx_d;

  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [PIXEL_BITS-1:0]  rdata;

  logic [POS_BITS-1:0]    op_k;
  logic [CFG_SAMP_BITS-1:0] op_s;
  logic [SB-1:0]          op_span, op_outm1;
  logic [NUM_W-1:0]       dsh;
  logic                   ge;
  logic [QB-1:0]          q_fin, start_val;
  logic                   last_cell;
  logic [SB:0]            c_end, r_end;
  logic [2*SB-1:0]        flat;

  fmp_ram #(.Width(PIXEL_BITS), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(head_value_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign pop_o = (state_q == BK_IDLE) && !empty_i;
  assign we    = pop_o && (head_i.kind == KIND_LOAD);
  assign waddr = AW'(32'(head_i.row) * MAX_WIDTH + 32'(head_i.col));
  assign raddr = AW'(32'(r_q) * MAX_WIDTH + 32'(c_q));

  // operand select for the four divisions: row pair, then column pair
  always_comb begin
    op_k     = sel_q[0] ? '0 : (sel_q[1] ? kcol_q : krow_q);
    op_s     = sel_q[1] ? cfg_i.samp_w : cfg_i.samp_h;
    op_span  = sel_q[1] ? cfg_i.in_w - cfg_i.pool_w : cfg_i.in_h - cfg_i.pool_h;
    op_outm1 = sel_q[1] ? cfg_i.out_w - 1'b1 : cfg_i.out_h - 1'b1;
    last_cell = sel_q[1] ? ({1'b0, kcol_q} >= op_outm1) : ({1'b0, krow_q} >= op_outm1);
  end

  assign dsh       = NUM_W'(den_q) << bit_q;
  assign ge        = rem_q >= dsh;
  assign q_fin     = quot_q | (ge ? QB'(1) << bit_q : '0);
  assign start_val = last_cell ? op_span : qa_q - q_fin;
  assign c_end     = {1'b0, c0_q} + {1'b0, cfg_i.pool_w} - 1'b1;
  assign r_end     = {1'b0, r0_q} + {1'b0, cfg_i.pool_h} - 1'b1;
  assign flat      = pr_q * cfg_i.in_w + (2*SB)'(pc_q);

  // compare stage: data for the beat issued last cycle
  always_comb begin
    best_d  = best_q;
    bidx_d  = bidx_q;
    first_d = first_q;
    if (pv_q) begin
      first_d = 1'b0;
      if (first_q || ($signed(rdata) > best_q)) begin
        best_d = $signed(rdata);
        bidx_d = flat[INDEX_BITS-1:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:  if (pop_o && head_i.kind == KIND_QUERY) state_d = BK_MUL;
      BK_MUL:   state_d = BK_DIV;
      BK_DIV: begin
        if (bit_q == '0) state_d = (sel_q == 2'd3) ? BK_SCAN : BK_MUL;
      end
      BK_SCAN: begin
        if ({1'b0, c_q} == c_end && {1'b0, r_q} == r_end) state_d = BK_DRAIN;
      end
      BK_DRAIN: state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    sel_d  = sel_q;
    rem_d  = rem_q;
    den_d  = den_q;
    bit_d  = bit_q;
    quot_d = quot_q;
    qa_d   = qa_q;
    r0_d   = r0_q;
    c0_d   = c0_q;
    r_d    = r_q;
    c_d    = c_q;
    pv_d   = 1'b0;
    case (state_q)
      BK_IDLE: sel_d = '0;
      BK_MUL: begin
        rem_d  = NUM_W'({op_k, op_s}) * NUM_W'(op_span);
        den_d  = {op_outm1, {CFG_SAMP_BITS{1'b0}}};
        bit_d  = 3'(QB - 1);
        quot_d = '0;
      end
      BK_DIV: begin
        if (ge) rem_d = rem_q - dsh;
        quot_d = q_fin;
        bit_d  = bit_q - 1'b1;
        if (bit_q == '0) begin
          sel_d = sel_q + 1'b1;
          if (!sel_q[0]) begin
            qa_d = q_fin;
          end else if (!sel_q[1]) begin
            r0_d = start_val;
          end else begin
            c0_d = start_val;
            r_d  = r0_q;
            c_d  = start_val;
          end
        end
      end
      BK_SCAN: begin
        pv_d = 1'b1;
        if ({1'b0, c_q} == c_end) begin
          c_d = c0_q;
          r_d = r_q + 1'b1;
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      BK_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      pv_q        <= 1'b0;
      first_q     <= 1'b1;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      pv_q        <= pv_d;
      first_q     <= (state_q == BK_IDLE) ? 1'b1 : first_d;
      res_valid_o <= (pop_o && head_i.kind == KIND_BAD) || (state_q == BK_DRAIN);
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= sel_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    bit_q  <= bit_d;
    quot_q <= quot_d;
    qa_q   <= qa_d;
    r0_q   <= r0_d;
    c0_q   <= c0_d;
    r_q    <= r_d;
    c_q    <= c_d;
    pr_q   <= r_q;
    pc_q   <= c_q;
    best_q <= best_d;
    bidx_q <= bidx_d;
    if (pop_o && head_i.kind == KIND_QUERY) begin
      krow_q <= head_i.row;
      kcol_q <= head_i.col;
    end
    if (state_q == BK_DRAIN) begin
      max_value_o <= best_d;
      max_index_o <= bidx_d;
      bad_query_o <= 1'b0;
    end else begin
      max_value_o <= '0;
      max_index_o <= '0;
      bad_query_o <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fractional_max_pool_2d_top.sv -----
`default_nettype none

// Channel   | Direction | Handshake                  | Beat contents
// ----------+-----------+----------------------------+-------------------------------
// request   | in        | start_i high, busy_o low   | req_type, pixel pos/value, cell
// result    | out       | res_valid_o, one cycle     | max_value, max_index, bad_query
// config    | in        | cfg_valid_i & cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A load is written to the plane store as it leaves the queue. The time a query
// takes is set by the shared 7-step divider (four divisions per query) and the
// single read port of the plane store, one window pixel per cycle.
// A bad query skips the divider. A two-beat queue parts front and back; busy_o
// rises only when it is full. Reset is asynchronous, active low; the plane store
// itself is not cleared. The receiver cannot stall results.

module fractional_max_pool_2d_top
  import fmp_pkg::*;
#(
  parameter int MAX_WIDTH  = FMP_MAX_WIDTH,
  parameter int MAX_HEIGHT = FMP_MAX_HEIGHT,
  parameter int PIXEL_BITS = FMP_PIXEL_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         req_type_i,
  input  wire logic [POS_BITS-1:0]          pixel_row_i,
  input  wire logic [POS_BITS-1:0]          pixel_col_i,
  input  wire logic signed [PIXEL_BITS-1:0] pixel_value_i,
  input  wire logic [POS_BITS-1:0]          out_row_i,
  input  wire logic [POS_BITS-1:0]          out_col_i,
  output logic                              res_valid_o,
  output logic signed [PIXEL_BITS-1:0]      max_value_o,
  output logic [INDEX_BITS-1:0]             max_index_o,
  output logic                              bad_query_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire logic [CFG_SAMP_BITS-1:0]     cfg_data_i
);

  cfg_t  cfg_q;
  item_t head;
  logic signed [PIXEL_BITS-1:0] head_value;
  logic  empty, pop;

  // config writes land at once; the port never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_w   <= 7'd64;
      cfg_q.in_h   <= 7'd64;
      cfg_q.out_w  <= 7'd32;
      cfg_q.out_h  <= 7'd32;
      cfg_q.pool_w <= 7'd2;
      cfg_q.pool_h <= 7'd2;
      cfg_q.samp_w <= '0;
      cfg_q.samp_h <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IN_WIDTH:    cfg_q.in_w   <= cfg_data_i[CFG_SIZE_BITS-1:0];
        CFG_IN_HEIGHT:   cfg_q.in_h   <= cfg_data_i[CFG_SIZE_BITS-1:0];
        CFG_OUT_WIDTH:   cfg_q.out_w  <= cfg_data_i[CFG_SIZE_BITS-1:0];
        CFG_OUT_HEIGHT:  cfg_q.out_h  <= cfg_data_i[CFG_SIZE_BITS-1:0];
        CFG_POOL_WIDTH:  cfg_q.pool_w <= cfg_data_i[CFG_SIZE_BITS-1:0];
        CFG_POOL_HEIGHT: cfg_q.pool_h <= cfg_data_i[CFG_SIZE_BITS-1:0];
        CFG_SAMPLE_W:    cfg_q.samp_w <= cfg_data_i;
        CFG_SAMPLE_H:    cfg_q.samp_h <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front end: accept, classify, queue
  fmp_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .pixel_row_i  (pixel_row_i),
    .pixel_col_i  (pixel_col_i),
    .pixel_value_i(pixel_value_i),
    .out_row_i    (out_row_i),
    .out_col_i    (out_col_i),
    .head_o       (head),
    .head_value_o (head_value),
    .empty_o      (empty),
    .pop_i        (pop)
  );

  // back end: store writes, window start division, window scan
  fmp_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .head_value_i(head_value),
    .empty_i     (empty),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .max_value_o (max_value_o),
    .max_index_o (max_index_o),
    .bad_query_o (bad_query_o)
  );

endmodule

`default_nettype wire

// ----- verif/fractional_max_pool_2d_top_test.sv -----
`timescale 1ns / 100ps

module fractional_max_pool_2d_top_test;
  import fmp_pkg::*;

  // Side of the corner region that is loaded before any query reads it.
  localparam int FILL_SIZE = 16;

  // Expected pooling results, in query order, with a mismatch count.
  class pool_scoreboard;
    logic [15:0] exp_value[$];
    logic [11:0] exp_index[$];
    logic        exp_bad[$];
    int          errors;
    int          checked;

    function void note_query(logic [15:0] v, logic [11:0] idx, logic bad);
      exp_value.push_back(v);
      exp_index.push_back(idx);
      exp_bad.push_back(bad);
    endfunction

    // Compare a result beat with the oldest expectation; bit 0 value, 1 index, 2 flag.
    function logic [2:0] check(input logic [15:0] v, input logic [11:0] idx,
        input logic bad, output logic [15:0] ev, output logic [11:0] ei,
        output logic eb);
      ev = exp_value.pop_front();
      ei = exp_index.pop_front();
      eb = exp_bad.pop_front();
      checked++;
      return {bad !== eb, idx !== ei, v !== ev};
    endfunction

    function int pending();
      return exp_value.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic                          req_type_i;
  logic [POS_BITS-1:0]           pixel_row_i;
  logic [POS_BITS-1:0]           pixel_col_i;
  logic signed [FMP_PIXEL_BITS-1:0] pixel_value_i;
  logic [POS_BITS-1:0]           out_row_i;
  logic [POS_BITS-1:0]           out_col_i;
  logic                          res_valid_o;
  logic signed [FMP_PIXEL_BITS-1:0] max_value_o;
  logic [INDEX_BITS-1:0]         max_index_o;
  logic                          bad_query_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]       cfg_index_i;
  logic [CFG_SAMP_BITS-1:0]      cfg_data_i;

  fractional_max_pool_2d_top DUT (.*);

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Shadow copy of the plane store and the register file.
  logic signed [15:0] plane_mirror[0:4095];
  int unsigned        in_w, in_h, out_w, out_h, pool_w, pool_h, samp_w, samp_h;
  pool_scoreboard     sb;
  int                 n_loads, n_queries, n_bad;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    sb.errors++;
  endtask

  // Check one result beat against the oldest expectation.
  task automatic check_result();
    logic [2:0]  miss;
    logic [15:0] ev;
    logic [11:0] ei;
    logic        eb;
    if (sb.pending() == 0) begin
      report_mismatch("unexpected result beat", 1, 0);
    end else begin
      miss = sb.check(max_value_o, max_index_o, bad_query_o, ev, ei, eb);
      if (miss[0]) report_mismatch("max_value", max_value_o, $signed(ev));
      if (miss[1]) report_mismatch("max_index", max_index_o, ei);
      if (miss[2]) report_mismatch("bad_query", bad_query_o, eb);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) check_result();
  end

  // Window start on one axis; the last cell sits flush against the far edge.
  function automatic int unsigned window_origin(int unsigned k, int unsigned s,
      int unsigned in_sz, int unsigned out_sz, int unsigned pool);
    longint unsigned span, den;
    span = in_sz - pool;
    if (k + 1 >= out_sz) return span;
    den = longint'(out_sz - 1) << 16;
    return 32'(((((longint'(k) << 16) + s) * span) / den) - ((longint'(s) * span) / den));
  endfunction

  function automatic bit axis_valid(int unsigned in_sz, int unsigned out_sz,
      int unsigned pool);
    if (in_sz == 0 || out_sz == 0 || pool == 0 || in_sz > 64) return 0;
    return out_sz + pool - 1 <= in_sz;
  endfunction

  // Work out the pooled maximum for an accepted query.
  function automatic void predict_pool(int unsigned row, int unsigned col);
    int unsigned r0, c0;
    logic signed [15:0] best;
    int unsigned best_idx;
    bit first;
    first = 1;
    if (!axis_valid(in_w, out_w, pool_w) || !axis_valid(in_h, out_h, pool_h) ||
        row >= out_h || col >= out_w) begin
      sb.note_query('0, '0, 1'b1);
      n_bad++;
      return;
    end
    r0 = window_origin(row, samp_h, in_h, out_h, pool_h);
    c0 = window_origin(col, samp_w, in_w, out_w, pool_w);
    best = 0;
    best_idx = r0 * in_w + c0;
    for (int unsigned r = r0; r < r0 + pool_h; r++) begin
      for (int unsigned c = c0; c < c0 + pool_w; c++) begin
        logic signed [15:0] v;
        v = plane_mirror[(r * 64 + c) % 4096];
        if (first || v > best) begin
          best = v;
          best_idx = r * in_w + c;
          first = 0;
        end
      end
    end
    sb.note_query(best, best_idx[11:0], 1'b0);
  endfunction

  // Present one request beat and hold it until the block takes it; with no gap
  // start stays high into the next beat.
  task automatic send_item(input bit is_query, input int unsigned a, input int unsigned b,
      input logic [15:0] v);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i       <= 1'b1;
    req_type_i    <= is_query;
    pixel_row_i   <= is_query ? POS_BITS'($urandom) : POS_BITS'(a);
    pixel_col_i   <= is_query ? POS_BITS'($urandom) : POS_BITS'(b);
    pixel_value_i <= is_query ? 16'($urandom) : v;
    out_row_i     <= is_query ? POS_BITS'(a) : POS_BITS'($urandom);
    out_col_i     <= is_query ? POS_BITS'(b) : POS_BITS'($urandom);
    do @(posedge clk_i); while (busy_o);
    if (is_query) begin
      predict_pool(a, b);
      n_queries++;
    end else begin
      plane_mirror[a * 64 + b] = v;
      n_loads++;
    end
    @(negedge clk_i);
  endtask

  // Drop start and let the block drain before touching registers.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[15:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_IN_WIDTH:    in_w   = val & 'h7f;
      CFG_IN_HEIGHT:   in_h   = val & 'h7f;
      CFG_OUT_WIDTH:   out_w  = val & 'h7f;
      CFG_OUT_HEIGHT:  out_h  = val & 'h7f;
      CFG_POOL_WIDTH:  pool_w = val & 'h7f;
      CFG_POOL_HEIGHT: pool_h = val & 'h7f;
      CFG_SAMPLE_W:    samp_w = val & 'hffff;
      CFG_SAMPLE_H:    samp_h = val & 'hffff;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_geometry(input int unsigned iw, ih, ow, oh, pw, ph, sw, sh);
    wait_idle();
    write_reg(CFG_IN_WIDTH, iw);
    write_reg(CFG_IN_HEIGHT, ih);
    write_reg(CFG_OUT_WIDTH, ow);
    write_reg(CFG_OUT_HEIGHT, oh);
    write_reg(CFG_POOL_WIDTH, pw);
    write_reg(CFG_POOL_HEIGHT, ph);
    write_reg(CFG_SAMPLE_W, sw);
    write_reg(CFG_SAMPLE_H, sh);
    cfg_valid_i <= 1'b0;
  endtask

  // Fill the corner region once; the windows of the random phases stay inside it.
  task automatic fill_plane();
    for (int r = 0; r < FILL_SIZE; r++)
      for (int c = 0; c < FILL_SIZE; c++)
        send_item(0, r, c, 16'($urandom));
  endtask

  initial begin
    sb = new();
    start_i = 0; req_type_i = 0; pixel_row_i = 0; pixel_col_i = 0; pixel_value_i = 0;
    out_row_i = 0; out_col_i = 0; cfg_valid_i = 0; cfg_index_i = CFG_IN_WIDTH;
    cfg_data_i = 0;
    in_w = 64; in_h = 64; out_w = 32; out_h = 32; pool_w = 2; pool_h = 2;
    samp_w = 0; samp_h = 0;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    fill_plane();
    // Directed: extreme pixels, reset geometry corners, out-of-range cells.
    send_item(0, 0, 0, 16'h7fff);
    send_item(0, 63, 63, 16'h8000);
    send_item(0, 62, 62, 16'h8000);
    send_item(0, 62, 63, 16'h8000);
    send_item(0, 63, 62, 16'h8001);
    send_item(0, 0, 1, 16'h7fff); // tie: first in raster order wins
    send_item(1, 0, 0, 0);
    send_item(1, 31, 31, 0);
    send_item(1, 32, 0, 0);
    send_item(1, 0, 63, 0);
    send_item(1, 63, 63, 0);
    set_geometry(FILL_SIZE, FILL_SIZE, 1, 1, FILL_SIZE, FILL_SIZE, 65535, 65535);
    send_item(1, 0, 0, 0);
    set_geometry(FILL_SIZE, FILL_SIZE, FILL_SIZE, FILL_SIZE, 1, 1, 65535, 0);
    send_item(1, FILL_SIZE - 1, 0, 0);
    send_item(1, 5, FILL_SIZE - 2, 0);
    set_geometry(1, 1, 1, 1, 1, 1, 0, 0);
    send_item(1, 0, 0, 0);
    // Broken configurations: zero sizes, oversize input, too many outputs.
    set_geometry(0, 64, 8, 8, 2, 2, 0, 0);
    send_item(1, 0, 0, 0);
    set_geometry(65, 64, 8, 8, 2, 2, 0, 0);
    send_item(1, 0, 0, 0);
    set_geometry(10, 10, 10, 10, 2, 2, 0, 0);
    send_item(1, 1, 1, 0);
    set_geometry(127, 127, 127, 127, 127, 127, 0, 0);
    send_item(1, 0, 0, 0);

    // Random phases: mostly valid geometries with small windows.
    for (int ph = 0; ph < 10; ph++) begin
      int unsigned iw, ih, ow, oh, pw, ph_;
      iw  = $urandom_range(1, FILL_SIZE);
      ih  = $urandom_range(1, FILL_SIZE);
      pw  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, iw)
                                         : $urandom_range(1, (iw < 4) ? iw : 4);
      ph_ = ($urandom_range(0, 5) == 0) ? $urandom_range(1, ih)
                                         : $urandom_range(1, (ih < 4) ? ih : 4);
      ow  = $urandom_range(1, iw - pw + 1);
      oh  = $urandom_range(1, ih - ph_ + 1);
      if (ph == 9) ow = ow + $urandom_range(1, 3); // mis-sized phase
      set_geometry(iw, ih, ow, oh, pw, ph_, $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
      for (int i = 0; i < 52; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_item(0, $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
        else if ($urandom_range(0, 9) == 0)
          send_item(1, $urandom_range(0, 63), $urandom_range(0, 63), 0);
        else
          send_item(1, $urandom_range(0, oh - 1), $urandom_range(0, ow - 1), 0);
      end
    end

    start_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("Covered %0d loads and %0d queries (%0d flagged), %0d results checked.",
             n_loads, n_queries, n_bad, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("fractional_max_pool_2d_top_test: clean");
    end else begin
      $display("fractional_max_pool_2d_top_test: errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8000000;
    $display("Timeout with %0d results outstanding.", sb.pending());
    $display("fractional_max_pool_2d_top_test: errors");
    $finish;
  end

endmodule
